// ===== hdl/vax_pkg.sv =====
// ----------------------------------------------------------------------------
// vax_pkg
// Shared types, widths and helpers of the Q16.16 three-component vector ALU.
// ----------------------------------------------------------------------------
package vax_pkg;

  localparam int Q_W    = 32;
  localparam int FRAC_W = 16;
  localparam int LANES  = 3;
  localparam int EPS_W  = 16;
  localparam int PROD_W = 2 * Q_W;
  localparam int WIDE_W = PROD_W + 2;
  localparam int NUM_W  = Q_W + FRAC_W;
  localparam int RAD_W  = PROD_W;
  localparam int ROOT_W = RAD_W / 2;

  typedef enum logic [3:0] {
    OP_ADD       = 4'd0,
    OP_SUB       = 4'd1,
    OP_MUL       = 4'd2,
    OP_DIV       = 4'd3,
    OP_CROSS     = 4'd4,
    OP_DOT       = 4'd5,
    OP_LENGTH    = 4'd6,
    OP_NORMALIZE = 4'd7,
    OP_DIRECTION = 4'd8,
    OP_SCALE     = 4'd9,
    OP_INVERT    = 4'd10,
    OP_EQUALS    = 4'd11,
    OP_ISZERO    = 4'd12,
    OP_NONE      = 4'd15
  } op_t;

  typedef logic [LANES-1:0][Q_W-1:0] vec_t;
  typedef logic signed [WIDE_W-1:0]  wide_t;

  typedef struct packed {
    logic [Q_W-1:0] value;
    logic           clip;
  } sat_t;

  // classified item handed from the front to the back
  typedef struct packed {
    op_t            op;
    vec_t           a;
    vec_t           b;
    vec_t           p;
    logic [Q_W-1:0] s;
    logic           cmp;
    logic           blocked;
    logic           sat;
  } fe_item_t;

  function automatic sat_t sat_q(input wide_t v);
    sat_t  r;
    wide_t hi;
    wide_t lo;
    hi = {{(WIDE_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      r.value = {1'b0, {(Q_W-1){1'b1}}};
      r.clip  = 1'b1;
    end else if (v < lo) begin
      r.value = {1'b1, {(Q_W-1){1'b0}}};
      r.clip  = 1'b1;
    end else begin
      r.value = v[Q_W-1:0];
      r.clip  = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== hdl/vax_ifs.sv =====
// ----------------------------------------------------------------------------
// vax_ifs
// Channel interfaces: input items, result items and the epsilon write port.
// ----------------------------------------------------------------------------
interface vax_in_if;
  logic                          valid;
  logic                          ready;
  logic [3:0]                    mode;
  logic signed [vax_pkg::Q_W-1:0] a_x;
  logic signed [vax_pkg::Q_W-1:0] a_y;
  logic signed [vax_pkg::Q_W-1:0] a_z;
  logic signed [vax_pkg::Q_W-1:0] b_x;
  logic signed [vax_pkg::Q_W-1:0] b_y;
  logic signed [vax_pkg::Q_W-1:0] b_z;
  logic signed [vax_pkg::Q_W-1:0] scale_factor;
  modport source (output valid, mode, a_x, a_y, a_z, b_x, b_y, b_z, scale_factor,
                  input ready);
  modport sink (input valid, mode, a_x, a_y, a_z, b_x, b_y, b_z, scale_factor,
                output ready);
endinterface

interface vax_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [vax_pkg::Q_W-1:0] result_x;
  logic signed [vax_pkg::Q_W-1:0] result_y;
  logic signed [vax_pkg::Q_W-1:0] result_z;
  logic signed [vax_pkg::Q_W-1:0] result_scalar;
  logic                          compare_true;
  logic                          divide_blocked;
  logic                          saturated;
  modport source (output valid, result_x, result_y, result_z, result_scalar,
                  compare_true, divide_blocked, saturated, input ready);
  modport sink (input valid, result_x, result_y, result_z, result_scalar,
                compare_true, divide_blocked, saturated, output ready);
endinterface

interface vax_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [vax_pkg::EPS_W-1:0]     data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== hdl/vax_front.sv =====
// ----------------------------------------------------------------------------
// vax_front
// Takes input beats, decodes the mode, checks divisors and forms b minus a.
// ----------------------------------------------------------------------------
module vax_front (
  input  logic              clk,
  input  logic              rst_n,
  vax_in_if.sink            in_ch,
  vax_cfg_if.sink           cfg_ch,
  output vax_pkg::fe_item_t item,
  output logic              item_vld,
  input  logic              item_rdy
);

  logic [vax_pkg::EPS_W-1:0] eps_r;
  vax_pkg::fe_item_t         fe_r;
  vax_pkg::fe_item_t         fe_nxt;
  logic                      fe_vld_r;
  logic                      fe_vld_nxt;
  logic                      take;

  always_comb begin
    vax_pkg::vec_t           a_v;
    vax_pkg::vec_t           b_v;
    vax_pkg::vec_t           t_v;
    vax_pkg::op_t            op;
    vax_pkg::sat_t           ds;
    logic [vax_pkg::Q_W:0]   mag;
    logic                    blk;
    logic                    dsat;
    a_v  = {in_ch.a_z, in_ch.a_y, in_ch.a_x};
    b_v  = {in_ch.b_z, in_ch.b_y, in_ch.b_x};
    op   = (in_ch.mode > 4'(vax_pkg::OP_ISZERO)) ? vax_pkg::OP_NONE
                                                  : vax_pkg::op_t'(in_ch.mode);
    blk  = 1'b0;
    dsat = 1'b0;
    for (int i = 0; i < vax_pkg::LANES; i++) begin
      ds     = vax_pkg::sat_q(vax_pkg::wide_t'($signed(b_v[i]))
                              - vax_pkg::wide_t'($signed(a_v[i])));
      t_v[i] = ds.value;
      dsat   = dsat | ds.clip;
      mag    = b_v[i][vax_pkg::Q_W-1]
             ? ((vax_pkg::Q_W+1)'(0) - {b_v[i][vax_pkg::Q_W-1], b_v[i]})
             : {1'b0, b_v[i]};
      blk    = blk | (mag == '0) | (mag < (vax_pkg::Q_W+1)'(eps_r));
    end
    fe_nxt.op      = op;
    fe_nxt.a       = a_v;
    fe_nxt.b       = b_v;
    fe_nxt.p       = (op == vax_pkg::OP_DIRECTION) ? t_v : a_v;
    fe_nxt.s       = in_ch.scale_factor;
    fe_nxt.cmp     = ((op == vax_pkg::OP_EQUALS) && (a_v == b_v))
                   || ((op == vax_pkg::OP_ISZERO) && (a_v == '0));
    fe_nxt.blocked = (op == vax_pkg::OP_DIV) && blk;
    fe_nxt.sat     = (op == vax_pkg::OP_DIRECTION) && dsat;
  end

  assign in_ch.ready  = !fe_vld_r || item_rdy;
  assign take         = in_ch.valid && in_ch.ready;
  assign fe_vld_nxt   = take ? 1'b1 : (item_rdy ? 1'b0 : fe_vld_r);
  assign cfg_ch.ready = 1'b1;
  assign item         = fe_r;
  assign item_vld     = fe_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fe_vld_r <= 1'b0;
      eps_r    <= vax_pkg::EPS_W'(1);
    end else begin
      fe_vld_r <= fe_vld_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        eps_r <= cfg_ch.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fe_r <= fe_nxt;
    end
  end

endmodule

// ===== hdl/vax_queue.sv =====
// ----------------------------------------------------------------------------
// vax_queue
// Small register queue between the front and the back.
// ----------------------------------------------------------------------------
module vax_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  vax_pkg::fe_item_t push_item,
  input  logic              push_vld,
  output logic              push_rdy,
  output vax_pkg::fe_item_t pop_item,
  output logic              pop_vld,
  input  logic              pop_rdy
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  vax_pkg::fe_item_t mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic              push;
  logic              pop;

  assign push_rdy   = (cnt_r != CNT_W'(DEPTH));
  assign pop_vld    = (cnt_r != '0);
  assign push       = push_vld && push_rdy;
  assign pop        = pop_vld && pop_rdy;
  assign pop_item   = mem_r[rd_ptr_r];
  assign wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
  assign cnt_nxt    = cnt_r + CNT_W'(push) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== hdl/vax_sqrt.sv =====
// ----------------------------------------------------------------------------
// vax_sqrt
// Pipelined integer square root, two radicand bits per stage.
// ----------------------------------------------------------------------------
module vax_sqrt #(
  parameter int TAG_W = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [vax_pkg::RAD_W-1:0]  rad,
  input  logic [TAG_W-1:0]           tag_in,
  output logic                       out_vld,
  output logic [vax_pkg::ROOT_W-1:0] root,
  output logic [TAG_W-1:0]           tag_out
);

  localparam int NST   = vax_pkg::ROOT_W;
  localparam int REM_W = vax_pkg::ROOT_W + 1;

  logic [vax_pkg::RAD_W-1:0]  rad_r  [NST];
  logic [REM_W-1:0]           rem_r  [NST];
  logic [vax_pkg::ROOT_W-1:0] root_r [NST];
  logic [TAG_W-1:0]           tag_r  [NST];
  logic                       vld_r  [NST];

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic [vax_pkg::RAD_W-1:0]  rad_s;
    logic [REM_W-1:0]           rem_s;
    logic [vax_pkg::ROOT_W-1:0] root_s;
    logic [TAG_W-1:0]           tag_s;
    logic                       vld_s;
    logic [REM_W+1:0]           rin;
    logic [REM_W+1:0]           trial;
    logic                       ge;

    if (k == 0) begin : g_src
      assign rad_s  = rad;
      assign rem_s  = '0;
      assign root_s = '0;
      assign tag_s  = tag_in;
      assign vld_s  = in_vld;
    end else begin : g_src
      assign rad_s  = rad_r[k-1];
      assign rem_s  = rem_r[k-1];
      assign root_s = root_r[k-1];
      assign tag_s  = tag_r[k-1];
      assign vld_s  = vld_r[k-1];
    end

    // bring down two bits, try 4*root+1
    assign rin   = {rem_s, rad_s[vax_pkg::RAD_W-1 -: 2]};
    assign trial = {1'b0, root_s, 2'b01};
    assign ge    = (rin >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_s;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= rad_s << 2;
        rem_r[k]  <= ge ? REM_W'(rin - trial) : REM_W'(rin);
        root_r[k] <= {root_s[vax_pkg::ROOT_W-2:0], ge};
        tag_r[k]  <= tag_s;
      end
    end
  end

  assign out_vld = vld_r[NST-1];
  assign root    = root_r[NST-1];
  assign tag_out = tag_r[NST-1];

endmodule

// ===== hdl/vax_div.sv =====
// ----------------------------------------------------------------------------
// vax_div
// Pipelined unsigned restoring divider, three lanes, one quotient bit a stage.
// ----------------------------------------------------------------------------
module vax_div #(
  parameter int TAG_W = 8
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             en,
  input  logic                                             in_vld,
  input  logic [vax_pkg::LANES-1:0][vax_pkg::NUM_W-1:0]    num,
  input  vax_pkg::vec_t                                    den,
  input  logic [TAG_W-1:0]                                 tag_in,
  output logic                                             out_vld,
  output logic [vax_pkg::LANES-1:0][vax_pkg::NUM_W-1:0]    quo,
  output logic [TAG_W-1:0]                                 tag_out
);

  localparam int NST = vax_pkg::NUM_W;
  localparam int Q_W = vax_pkg::Q_W;

  logic [vax_pkg::LANES-1:0][vax_pkg::NUM_W-1:0] num_r [NST];
  logic [vax_pkg::LANES-1:0][vax_pkg::NUM_W-1:0] quo_r [NST];
  logic [vax_pkg::LANES-1:0][Q_W-1:0]            rem_r [NST];
  vax_pkg::vec_t                                 den_r [NST];
  logic [TAG_W-1:0]                              tag_r [NST];
  logic                                          vld_r [NST];

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic [vax_pkg::LANES-1:0][vax_pkg::NUM_W-1:0] num_s;
    logic [vax_pkg::LANES-1:0][vax_pkg::NUM_W-1:0] quo_s;
    logic [vax_pkg::LANES-1:0][Q_W-1:0]            rem_s;
    vax_pkg::vec_t                                 den_s;
    logic [TAG_W-1:0]                              tag_s;
    logic                                          vld_s;
    logic [vax_pkg::LANES-1:0][vax_pkg::NUM_W-1:0] num_o;
    logic [vax_pkg::LANES-1:0][vax_pkg::NUM_W-1:0] quo_o;
    logic [vax_pkg::LANES-1:0][Q_W-1:0]            rem_o;

    if (k == 0) begin : g_src
      assign num_s = num;
      assign quo_s = '0;
      assign rem_s = '0;
      assign den_s = den;
      assign tag_s = tag_in;
      assign vld_s = in_vld;
    end else begin : g_src
      assign num_s = num_r[k-1];
      assign quo_s = quo_r[k-1];
      assign rem_s = rem_r[k-1];
      assign den_s = den_r[k-1];
      assign tag_s = tag_r[k-1];
      assign vld_s = vld_r[k-1];
    end

    always_comb begin
      logic [Q_W:0] rin;
      logic         ge;
      for (int i = 0; i < vax_pkg::LANES; i++) begin
        rin      = {rem_s[i], num_s[i][vax_pkg::NUM_W-1]};
        ge       = (rin >= {1'b0, den_s[i]});
        rem_o[i] = ge ? Q_W'(rin - {1'b0, den_s[i]}) : Q_W'(rin);
        quo_o[i] = {quo_s[i][vax_pkg::NUM_W-2:0], ge};
        num_o[i] = num_s[i] << 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_s;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[k] <= num_o;
        quo_r[k] <= quo_o;
        rem_r[k] <= rem_o;
        den_r[k] <= den_s;
        tag_r[k] <= tag_s;
      end
    end
  end

  assign out_vld = vld_r[NST-1];
  assign quo     = quo_r[NST-1];
  assign tag_out = tag_r[NST-1];

endmodule

// ===== hdl/vax_back.sv =====
// ----------------------------------------------------------------------------
// vax_back
// Execution pipeline: products, sums and clipping, square root, division,
// then the result register toward the output channel.
// ----------------------------------------------------------------------------
module vax_back (
  input  logic              clk,
  input  logic              rst_n,
  input  vax_pkg::fe_item_t item,
  input  logic              item_vld,
  output logic              item_rdy,
  vax_out_if.source         out_ch
);

  localparam int Q_W   = vax_pkg::Q_W;
  localparam int LANES = vax_pkg::LANES;

  typedef struct packed {
    vax_pkg::op_t                          op;
    vax_pkg::vec_t                         vpre;
    logic [Q_W-1:0]                        spre;
    logic                                  sat;
    logic                                  cmp;
    logic                                  blocked;
    logic [LANES-1:0][vax_pkg::NUM_W-1:0]  num;
    logic [LANES-1:0]                      neg;
    vax_pkg::vec_t                         den;
  } sq_tag_t;

  typedef struct packed {
    vax_pkg::op_t     op;
    vax_pkg::vec_t    vpre;
    logic [Q_W-1:0]   scalar;
    logic             sat;
    logic             cmp;
    logic             blocked;
    logic [LANES-1:0] neg;
    logic             zero;
  } dv_tag_t;

  typedef struct packed {
    vax_pkg::vec_t  res;
    logic [Q_W-1:0] scalar;
    logic           cmp;
    logic           blocked;
    logic           sat;
  } res_t;

  logic                                 en;
  logic                                 m_vld_r;
  vax_pkg::fe_item_t                    m_item_r;
  logic signed [vax_pkg::PROD_W-1:0]    m_l_r [LANES];
  logic signed [vax_pkg::PROD_W-1:0]    m_r_r [LANES];
  logic signed [vax_pkg::PROD_W-1:0]    l_nxt [LANES];
  logic signed [vax_pkg::PROD_W-1:0]    r_nxt [LANES];
  sq_tag_t                              sq_tag;
  sq_tag_t                              sq_tag_o;
  logic [vax_pkg::RAD_W-1:0]            sumsq;
  logic                                 sq_vld_o;
  logic [vax_pkg::ROOT_W-1:0]           len;
  dv_tag_t                              dv_tag;
  dv_tag_t                              dv_tag_o;
  logic [LANES-1:0][vax_pkg::NUM_W-1:0] dv_num;
  vax_pkg::vec_t                        dv_den;
  logic                                 dv_vld_o;
  logic [LANES-1:0][vax_pkg::NUM_W-1:0] quo;
  res_t                                 res_nxt;
  res_t                                 out_r;
  logic                                 out_vld_r;

  // whole back end advances unless a result is held at the output
  assign en       = !out_vld_r || out_ch.ready;
  assign item_rdy = en;

  // multiply stage: lane products, second set used only for cross
  for (genvar i = 0; i < LANES; i++) begin : g_mul
    localparam int I1 = (i + 1) % LANES;
    localparam int I2 = (i + 2) % LANES;
    always_comb begin
      logic [Q_W-1:0] x;
      logic [Q_W-1:0] y;
      unique case (item.op)
        vax_pkg::OP_LENGTH, vax_pkg::OP_NORMALIZE, vax_pkg::OP_DIRECTION: begin
          x = item.p[i];
          y = item.p[i];
        end
        vax_pkg::OP_SCALE: begin
          x = item.a[i];
          y = item.s;
        end
        vax_pkg::OP_CROSS: begin
          x = item.a[I1];
          y = item.b[I2];
        end
        default: begin
          x = item.a[i];
          y = item.b[i];
        end
      endcase
      l_nxt[i] = $signed(x) * $signed(y);
      r_nxt[i] = $signed(item.a[I2]) * $signed(item.b[I1]);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_l_r[i] <= l_nxt[i];
        m_r_r[i] <= r_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (en) begin
      m_vld_r <= item_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_item_r <= item;
    end
  end

  // combine stage: sums, floor shifts, clipping, divider operands
  always_comb begin
    vax_pkg::wide_t    pre;
    vax_pkg::wide_t    la;
    vax_pkg::wide_t    ra;
    vax_pkg::wide_t    aw;
    vax_pkg::wide_t    bw;
    vax_pkg::wide_t    dsum;
    vax_pkg::sat_t     sv;
    logic [Q_W-1:0]    src;
    logic [Q_W-1:0]    mag;
    logic              clip;
    clip = m_item_r.sat;
    dsum = '0;
    for (int i = 0; i < LANES; i++) begin
      la = vax_pkg::wide_t'(m_l_r[i]);
      ra = vax_pkg::wide_t'(m_r_r[i]);
      aw = vax_pkg::wide_t'($signed(m_item_r.a[i]));
      bw = vax_pkg::wide_t'($signed(m_item_r.b[i]));
      dsum = dsum + la;
      case (m_item_r.op)
        vax_pkg::OP_ADD:                    pre = aw + bw;
        vax_pkg::OP_SUB:                    pre = aw - bw;
        vax_pkg::OP_MUL, vax_pkg::OP_SCALE: pre = la >>> vax_pkg::FRAC_W;
        vax_pkg::OP_CROSS:                  pre = (la - ra) >>> vax_pkg::FRAC_W;
        vax_pkg::OP_INVERT:                 pre = -aw;
        default:                            pre = '0;
      endcase
      sv = vax_pkg::sat_q(pre);
      sq_tag.vpre[i] = sv.value;
      clip = clip | sv.clip;
      src  = (m_item_r.op == vax_pkg::OP_DIV) ? m_item_r.a[i] : m_item_r.p[i];
      mag  = src[Q_W-1] ? (Q_W'(0) - src) : src;
      sq_tag.num[i] = {mag, {vax_pkg::FRAC_W{1'b0}}};
      sq_tag.neg[i] = src[Q_W-1]
                    ^ ((m_item_r.op == vax_pkg::OP_DIV) && m_item_r.b[i][Q_W-1]);
      sq_tag.den[i] = m_item_r.b[i][Q_W-1] ? (Q_W'(0) - m_item_r.b[i]) : m_item_r.b[i];
    end
    sv = vax_pkg::sat_q((m_item_r.op == vax_pkg::OP_DOT) ? (dsum >>> vax_pkg::FRAC_W)
                                                         : vax_pkg::wide_t'(0));
    sq_tag.spre    = sv.value;
    sq_tag.sat     = clip | sv.clip;
    sq_tag.op      = m_item_r.op;
    sq_tag.cmp     = m_item_r.cmp;
    sq_tag.blocked = m_item_r.blocked;
    // squares are never negative
    sumsq = m_l_r[0] + m_l_r[1] + m_l_r[2];
  end

  vax_sqrt #(
    .TAG_W ($bits(sq_tag_t))
  ) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (m_vld_r),
    .rad     (sumsq),
    .tag_in  (sq_tag),
    .out_vld (sq_vld_o),
    .root    (len),
    .tag_out (sq_tag_o)
  );

  // divider entry: divide uses |b|, normalize and direction use the length
  always_comb begin
    vax_pkg::sat_t ls;
    ls = vax_pkg::sat_q(vax_pkg::wide_t'(len));
    for (int i = 0; i < LANES; i++) begin
      dv_num[i] = sq_tag_o.num[i];
      dv_den[i] = (sq_tag_o.op == vax_pkg::OP_DIV) ? sq_tag_o.den[i] : len;
    end
    dv_tag.op      = sq_tag_o.op;
    dv_tag.vpre    = sq_tag_o.vpre;
    dv_tag.cmp     = sq_tag_o.cmp;
    dv_tag.blocked = sq_tag_o.blocked;
    dv_tag.neg     = sq_tag_o.neg;
    dv_tag.zero    = (sq_tag_o.op == vax_pkg::OP_DIV) ? sq_tag_o.blocked : (len == '0);
    if (sq_tag_o.op == vax_pkg::OP_LENGTH) begin
      dv_tag.scalar = ls.value;
      dv_tag.sat    = sq_tag_o.sat | ls.clip;
    end else begin
      dv_tag.scalar = sq_tag_o.spre;
      dv_tag.sat    = sq_tag_o.sat;
    end
  end

  vax_div #(
    .TAG_W ($bits(dv_tag_t))
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (sq_vld_o),
    .num     (dv_num),
    .den     (dv_den),
    .tag_in  (dv_tag),
    .out_vld (dv_vld_o),
    .quo     (quo),
    .tag_out (dv_tag_o)
  );

  // sign and clip quotients, pick the lane results
  always_comb begin
    vax_pkg::wide_t qw;
    vax_pkg::sat_t  qs;
    logic           use_q;
    logic           clip;
    use_q = dv_tag_o.op inside {vax_pkg::OP_DIV, vax_pkg::OP_NORMALIZE,
                                vax_pkg::OP_DIRECTION};
    clip  = dv_tag_o.sat;
    for (int i = 0; i < LANES; i++) begin
      qw = vax_pkg::wide_t'(quo[i]);
      qs = vax_pkg::sat_q(dv_tag_o.neg[i] ? -qw : qw);
      if (!use_q) begin
        res_nxt.res[i] = dv_tag_o.vpre[i];
      end else if (dv_tag_o.zero) begin
        res_nxt.res[i] = '0;
      end else begin
        res_nxt.res[i] = qs.value;
        clip = clip | qs.clip;
      end
    end
    res_nxt.scalar  = dv_tag_o.scalar;
    res_nxt.cmp     = dv_tag_o.cmp;
    res_nxt.blocked = dv_tag_o.blocked;
    res_nxt.sat     = clip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld_o;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= res_nxt;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.result_x       = out_r.res[0];
  assign out_ch.result_y       = out_r.res[1];
  assign out_ch.result_z       = out_r.res[2];
  assign out_ch.result_scalar  = out_r.scalar;
  assign out_ch.compare_true   = out_r.cmp;
  assign out_ch.divide_blocked = out_r.blocked;
  assign out_ch.saturated      = out_r.sat;

endmodule

// ===== hdl/vector3_alu_core.sv =====
// ----------------------------------------------------------------------------
// vector3_alu_core
// Q16.16 three-component vector ALU with saturating results.
// ----------------------------------------------------------------------------
// in_ch takes one item per beat: mode, vectors a and b and a scale factor.
// out_ch returns exactly one result beat per item, in order: vector,
// scalar, compare bit, divide-blocked and saturated flags.
// cfg_ch writes the divide epsilon; it is always ready. Write it only while
// no item is in flight.
// Throughput is one item per cycle unless out_ch stalls. An item passes
// the front register, the queue, the multiply stage, a 32-stage square
// root (two radicand bits per stage) and a 48-stage divider (one quotient
// bit per stage), then the output register.
// Reset clears all valid bits and the queue and sets epsilon to 1.
// When out_ch stalls the execution pipeline holds in place; the queue of
// QUEUE_DEPTH items plus the front register keep taking input beats until
// they fill, then in_ch.ready drops.
// ----------------------------------------------------------------------------
module vector3_alu_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  vax_in_if.sink    in_ch,
  vax_out_if.source out_ch,
  vax_cfg_if.sink   cfg_ch
);

  vax_pkg::fe_item_t fe_item;
  logic              fe_vld;
  logic              fe_rdy;
  vax_pkg::fe_item_t q_item;
  logic              q_vld;
  logic              q_rdy;

  vax_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .item     (fe_item),
    .item_vld (fe_vld),
    .item_rdy (fe_rdy)
  );

  vax_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_item (fe_item),
    .push_vld  (fe_vld),
    .push_rdy  (fe_rdy),
    .pop_item  (q_item),
    .pop_vld   (q_vld),
    .pop_rdy   (q_rdy)
  );

  vax_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .item     (q_item),
    .item_vld (q_vld),
    .item_rdy (q_rdy),
    .out_ch   (out_ch)
  );

endmodule

// ===== tb/vector3_alu_core_test.sv =====
// ----------------------------------------------------------------------------
// vector3_alu_core_test
// Drives random and corner-case Q16.16 vector items through the ALU, predicts
// each result in a scoreboard class and compares every field in order.
// ----------------------------------------------------------------------------
module vector3_alu_core_test;

  localparam int LATENCY     = 84;
  localparam int WATCH_LIMIT = 20000;
  localparam longint Q_HI = 64'sd2147483647;
  localparam longint Q_LO = -64'sd2147483648;

  typedef struct {
    vax_pkg::op_t       op;
    logic signed [31:0] a [3];
    logic signed [31:0] b [3];
    logic signed [31:0] s;
  } vec_item_t;

  typedef struct {
    logic signed [31:0] v [3];
    logic signed [31:0] scalar;
    logic cmp;
    logic blocked;
    logic sat;
  } vec_result_t;

  class vec_scoreboard;
    vec_result_t pending[$];
    logic [15:0] epsilon;
    int errors;

    function new();
      epsilon = 16'd1;
      errors  = 0;
    endfunction

    static function longint floor16(longint v);
      return v >>> 16;
    endfunction

    static function longint clip(longint v, ref logic f);
      if (v > Q_HI) begin
        f = 1'b1;
        return Q_HI;
      end
      if (v < Q_LO) begin
        f = 1'b1;
        return Q_LO;
      end
      return v;
    endfunction

    // floor of the 2^-16 sum, done in 128 bits to avoid overflow
    static function longint sum_shift(longint p0, longint p1, longint p2);
      logic signed [127:0] t;
      t = 128'(signed'(p0)) + 128'(signed'(p1)) + 128'(signed'(p2));
      t = t >>> 16;
      return longint'(t);
    endfunction

    static function longint unsigned root(logic [127:0] v);
      logic [127:0] r, bit_m;
      r = 0;
      bit_m = 128'd1 << 126;
      while (bit_m > v) bit_m >>= 2;
      while (bit_m != 0) begin
        if (v >= r + bit_m) begin
          v = v - (r + bit_m);
          r = (r >> 1) + bit_m;
        end else begin
          r = r >> 1;
        end
        bit_m >>= 2;
      end
      return longint'(r);
    endfunction

    static function longint unsigned mag(longint v[3]);
      logic [127:0] acc;
      acc = 0;
      for (int i = 0; i < 3; i++) acc += 128'(unsigned'(v[i] * v[i]));
      return root(acc);
    endfunction

    static function void unit(longint v[3], ref longint r[3]);
      longint unsigned len;
      len = mag(v);
      for (int i = 0; i < 3; i++) r[i] = (len == 0) ? 0 : (v[i] * 65536) / longint'(len);
    endfunction

    function void note_input(vec_item_t it);
      vec_result_t res;
      longint a[3], b[3], v[3], t[3], s, scalar, m;
      logic sat, blk, cmp;
      sat = 0; blk = 0; cmp = 0; scalar = 0; s = it.s;
      for (int i = 0; i < 3; i++) begin
        a[i] = it.a[i]; b[i] = it.b[i]; v[i] = 0;
      end
      case (it.op)
        vax_pkg::OP_ADD: for (int i = 0; i < 3; i++) v[i] = a[i] + b[i];
        vax_pkg::OP_SUB: for (int i = 0; i < 3; i++) v[i] = a[i] - b[i];
        vax_pkg::OP_MUL: for (int i = 0; i < 3; i++) v[i] = floor16(a[i] * b[i]);
        vax_pkg::OP_DIV: begin
          for (int i = 0; i < 3; i++) begin
            m = b[i] < 0 ? -b[i] : b[i];
            if (m == 0 || m < longint'(epsilon)) blk = 1;
          end
          if (!blk) for (int i = 0; i < 3; i++) v[i] = (a[i] * 65536) / b[i];
        end
        vax_pkg::OP_CROSS: begin
          v[0] = sum_shift(a[1] * b[2], -(a[2] * b[1]), 0);
          v[1] = sum_shift(a[2] * b[0], -(a[0] * b[2]), 0);
          v[2] = sum_shift(a[0] * b[1], -(a[1] * b[0]), 0);
        end
        vax_pkg::OP_DOT: scalar = sum_shift(a[0] * b[0], a[1] * b[1], a[2] * b[2]);
        vax_pkg::OP_LENGTH: scalar = longint'(mag(a));
        vax_pkg::OP_NORMALIZE: unit(a, v);
        vax_pkg::OP_DIRECTION: begin
          for (int i = 0; i < 3; i++) t[i] = clip(b[i] - a[i], sat);
          unit(t, v);
        end
        vax_pkg::OP_SCALE: for (int i = 0; i < 3; i++) v[i] = floor16(a[i] * s);
        vax_pkg::OP_INVERT: for (int i = 0; i < 3; i++) v[i] = -a[i];
        vax_pkg::OP_EQUALS: cmp = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
        vax_pkg::OP_ISZERO: cmp = (a[0] == 0) && (a[1] == 0) && (a[2] == 0);
        default: ;
      endcase
      for (int i = 0; i < 3; i++) res.v[i] = 32'(clip(v[i], sat));
      res.scalar  = 32'(clip(scalar, sat));
      res.cmp     = cmp;
      res.blocked = blk;
      res.sat     = sat;
      pending.push_back(res);
    endfunction

    function void check_result(vec_result_t got);
      vec_result_t exp;
      if (pending.size() == 0) begin
        $error("result beat with no expectation");
        errors++;
        return;
      end
      exp = pending.pop_front();
      for (int i = 0; i < 3; i++)
        if (got.v[i] !== exp.v[i]) begin
          $error("result_%0s exp %0d got %0d", i == 0 ? "x" : i == 1 ? "y" : "z",
                 exp.v[i], got.v[i]);
          errors++;
        end
      if (got.scalar !== exp.scalar) begin
        $error("result_scalar exp %0d got %0d", exp.scalar, got.scalar);
        errors++;
      end
      if (got.cmp !== exp.cmp) begin
        $error("compare_true exp %0b got %0b", exp.cmp, got.cmp);
        errors++;
      end
      if (got.blocked !== exp.blocked) begin
        $error("divide_blocked exp %0b got %0b", exp.blocked, got.blocked);
        errors++;
      end
      if (got.sat !== exp.sat) begin
        $error("saturated exp %0b got %0b", exp.sat, got.sat);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  vax_in_if  in_ch();
  vax_out_if out_ch();
  vax_cfg_if cfg_ch();

  vector3_alu_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  vec_scoreboard board = new();
  int idle_cycles = 0;
  bit hold_long = 0;
  bit hold_done = 0;

  initial begin
    in_ch.valid = 0; in_ch.mode = 0;
    in_ch.a_x = 0; in_ch.a_y = 0; in_ch.a_z = 0;
    in_ch.b_x = 0; in_ch.b_y = 0; in_ch.b_z = 0; in_ch.scale_factor = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0; cfg_ch.data = 0;
  end

  // result side: accept beats, stall at random, plus one long hold-off
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      vec_result_t r;
      r.v[0] = out_ch.result_x; r.v[1] = out_ch.result_y; r.v[2] = out_ch.result_z;
      r.scalar = out_ch.result_scalar; r.cmp = out_ch.compare_true;
      r.blocked = out_ch.divide_blocked; r.sat = out_ch.saturated;
      board.check_result(r);
    end
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (hold_long) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(0, 9) < 7);
  end

  initial begin
    wait (rst_n);
    repeat (300) @(posedge clk);
    hold_long = 1;
    repeat (400) @(posedge clk);
    hold_long = 0;
    hold_done = 1;
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n || hold_long)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [31:0] rand_q(int kind);
    case (kind)
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'(signed'($urandom_range(0, 262143)) - 131072);
      3: return 32'(signed'($urandom_range(0, 65535)) - 32768);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_item(vec_item_t it);
    @(posedge clk);
    in_ch.valid <= 1'b1;
    in_ch.mode  <= it.op;
    in_ch.a_x <= it.a[0]; in_ch.a_y <= it.a[1]; in_ch.a_z <= it.a[2];
    in_ch.b_x <= it.b[0]; in_ch.b_y <= it.b[1]; in_ch.b_z <= it.b[2];
    in_ch.scale_factor <= it.s;
    do @(posedge clk); while (!in_ch.ready);
    board.note_input(it);
    in_ch.valid <= 1'b0;
  endtask

  // back-to-back beats within a burst: valid stays high between items
  task automatic send_burst(vec_item_t its[$]);
    foreach (its[k]) begin
      if (k == 0) @(posedge clk);
      in_ch.valid <= 1'b1;
      in_ch.mode  <= its[k].op;
      in_ch.a_x <= its[k].a[0]; in_ch.a_y <= its[k].a[1]; in_ch.a_z <= its[k].a[2];
      in_ch.b_x <= its[k].b[0]; in_ch.b_y <= its[k].b[1]; in_ch.b_z <= its[k].b[2];
      in_ch.scale_factor <= its[k].s;
      do @(posedge clk); while (!in_ch.ready);
      board.note_input(its[k]);
    end
    in_ch.valid <= 1'b0;
  endtask

  task automatic write_epsilon(logic [15:0] value);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    board.epsilon = value;
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic vec_item_t make_item(vax_pkg::op_t op, int kind);
    vec_item_t it;
    it.op = op;
    for (int i = 0; i < 3; i++) begin
      it.a[i] = rand_q(kind < 0 ? $urandom_range(0, 5) : kind);
      it.b[i] = rand_q(kind < 0 ? $urandom_range(0, 5) : kind);
    end
    it.s = rand_q(kind < 0 ? $urandom_range(0, 5) : kind);
    if (op == vax_pkg::OP_EQUALS && $urandom_range(0, 1)) it.b = it.a;
    if (op == vax_pkg::OP_ISZERO && $urandom_range(0, 1)) it.a = '{0, 0, 0};
    if (op == vax_pkg::OP_DIRECTION && $urandom_range(0, 3) == 0) it.b = it.a;
    return it;
  endfunction

  initial begin
    vec_item_t it;
    vec_item_t burst[$];
    logic [15:0] eps_set [4] = '{16'd0, 16'd65535, 16'd1, 16'd300};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: every op at an extreme (max or min by op), zero vectors, blocked divides
    for (int k = 0; k < 13; k++) send_item(make_item(vax_pkg::op_t'(k), k % 2));
    it = make_item(vax_pkg::OP_NORMALIZE, 2); it.a = '{0, 0, 0}; send_item(it);
    it = make_item(vax_pkg::OP_DIRECTION, 2); it.b = it.a; send_item(it);
    it = make_item(vax_pkg::OP_DIV, 2); it.b[1] = 0; send_item(it);
    it = make_item(vax_pkg::OP_DIV, 3); it.b = '{32'sd1, -32'sd1, 32'sd1}; send_item(it);
    it = make_item(vax_pkg::OP_INVERT, 1); send_item(it);
    it = make_item(vax_pkg::OP_DIRECTION, 0);
    it.a = '{32'h80000000, 32'h80000000, 32'h80000000};
    send_item(it);
    it = make_item(vax_pkg::OP_NONE, -1); send_item(it);
    it = make_item(vax_pkg::OP_ADD, -1); it.op = vax_pkg::op_t'(4'd13); send_item(it);
    it = make_item(vax_pkg::OP_ADD, -1); it.op = vax_pkg::op_t'(4'd14); send_item(it);

    foreach (eps_set[p]) begin
      int sent;
      write_epsilon(eps_set[p]);
      sent = 0;
      while (sent < 350) begin
        int n;
        burst.delete();
        n = $urandom_range(1, 20);
        for (int j = 0; j < n; j++) begin
          it = make_item(vax_pkg::op_t'($urandom_range(0, 15)), -1);
          if (it.op == vax_pkg::OP_DIV && $urandom_range(0, 3) == 0)
            it.b[$urandom_range(0, 2)] = 32'($urandom_range(0, 2 * eps_set[p]))
                                          * ($urandom_range(0, 1) ? 1 : -1);
          burst.push_back(it);
        end
        send_burst(burst);
        sent += n;
        if (!(hold_long && $urandom_range(0, 1)))
          repeat ($urandom_range(0, 4) == 0 ? $urandom_range(1, 12) : 0) @(posedge clk);
      end
    end

    while (!hold_done || board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
